[rtl/pqh_pkg.sv]
`default_nettype none
package pqh_pkg;
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned CHD_W    = IDX_W + 2;
  localparam int unsigned ENT_W    = KEY_BITS + TAG_BITS;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [KEY_BITS-1:0] entry_key;
    logic [TAG_BITS-1:0] entry_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                out_valid;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic                top_valid;
    logic [KEY_BITS-1:0] top_key;
    logic [TAG_BITS-1:0] top_tag;
    logic [CNT_W-1:0]    entry_count;
  } rsp_t;
endpackage
`default_nettype wire

[rtl/pqh_ram.sv]
`default_nettype none
module pqh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/priority_queue_heap.sv]
`default_nettype none
// Bounded max-priority queue on a binary heap of up to CAPACITY entries held
// in one single-port-write, registered-read RAM. Each request beat (push, pop,
// remove by tag, or none) yields one result beat with status, the entry taken
// out, the new top entry and the count. Requests are served one at a time:
// in_stall_o stays high from acceptance until the result beat is taken. Every
// step is one RAM read or write, so the cost is set by the RAM port: a push
// and a pop walk the heap levels, at most log2 of CAPACITY of them; a remove
// first scans the store slot by slot up to the matching slot. Keys compare
// unsigned, larger outranks; ties are served in no set order. The store needs
// no clearing: slots at or past the count are never used.
module priority_queue_heap
  import pqh_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PU_RD  = 5'd1;
  localparam logic [4:0] S_PU_CMP = 5'd2;
  localparam logic [4:0] S_SR_RD  = 5'd3;
  localparam logic [4:0] S_SR_CMP = 5'd4;
  localparam logic [4:0] S_TK_RD  = 5'd5;
  localparam logic [4:0] S_TK_GOT = 5'd6;
  localparam logic [4:0] S_LS_RD  = 5'd7;
  localparam logic [4:0] S_LS_GOT = 5'd8;
  localparam logic [4:0] S_SD_L   = 5'd9;
  localparam logic [4:0] S_SD_R   = 5'd10;
  localparam logic [4:0] S_SD_CMP = 5'd11;
  localparam logic [4:0] S_WR_FIN = 5'd12;
  localparam logic [4:0] S_TOP_RD = 5'd13;
  localparam logic [4:0] S_TOP_GT = 5'd14;
  localparam logic [4:0] S_OUT    = 5'd15;

  logic [4:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;      // entries held
  logic [IDX_W-1:0]    hole_q, hole_d;    // current hole in the heap
  logic [CNT_W-1:0]    scan_q, scan_d;    // remove search position
  entry_t              ent_q, ent_d;      // entry being placed
  entry_t              best_q, best_d;    // left child during sift down
  logic [CHD_W-1:0]    chi_q, chi_d;      // left child index
  logic                sd_q, sd_d;        // sift down allowed
  logic                mv_q, mv_d;        // sift up moved the hole
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [1:0]          st_q, st_d;
  logic                ov_q, ov_d;
  entry_t              oe_q, oe_d;
  entry_t              top_q, top_d;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_wa, ram_ra;
  entry_t              ram_wd, ram_rd;
  logic [CHD_W-1:0]    lchild, rchild;
  logic [CNT_W-1:0]    cnt_dec;
  entry_t              cand;
  logic [CHD_W-1:0]    cand_i;

  pqh_ram #(.Width(ENT_W), .Depth(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  assign lchild  = CHD_W'({hole_q, 1'b1});
  assign rchild  = chi_q + 1'b1;
  assign cnt_dec = cnt_q - 1'b1;

  always_comb begin
    cand   = best_q;
    cand_i = chi_q;
    if ((rchild < CHD_W'(cnt_q)) && (ram_rd.key > best_q.key)) begin
      cand   = ram_rd;
      cand_i = rchild;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hole_d  = hole_q;
    scan_d  = scan_q;
    ent_d   = ent_q;
    best_d  = best_q;
    chi_d   = chi_q;
    sd_d    = sd_q;
    mv_d    = mv_q;
    tag_d   = tag_q;
    st_d    = st_q;
    ov_d    = ov_q;
    oe_d    = oe_q;
    top_d   = top_q;
    ram_we  = 1'b0;
    ram_wa  = hole_q;
    ram_wd  = ent_q;
    ram_ra  = hole_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d  = ST_OK;
          ov_d  = 1'b0;
          oe_d  = '0;
          sd_d  = 1'b0;
          mv_d  = 1'b0;
          tag_d = in_data_i.entry_tag;
          ent_d = '{key: in_data_i.entry_key, tag: in_data_i.entry_tag};
          case (in_data_i.req_type)
            REQ_PUSH: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                st_d    = ST_FULL;
                state_d = S_TOP_RD;
              end else begin
                hole_d  = cnt_q[IDX_W-1:0];
                cnt_d   = cnt_q + 1'b1;
                state_d = S_PU_RD;
              end
            end
            REQ_POP: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_TOP_RD;
              end else begin
                hole_d  = '0;
                state_d = S_TK_RD;
              end
            end
            REQ_REMOVE: begin
              if (cnt_q == '0) begin
                st_d    = ST_NOTFOUND;
                state_d = S_TOP_RD;
              end else begin
                scan_d  = '0;
                state_d = S_SR_RD;
              end
            end
            default: state_d = S_TOP_RD;
          endcase
        end
      end
      S_PU_RD: begin
        if (hole_q == '0) begin
          // At the root: go on down when the hole never moved up
          state_d = (sd_q && !mv_q) ? S_SD_L : S_WR_FIN;
        end else begin
          ram_ra  = IDX_W'((hole_q - 1'b1) >> 1);
          state_d = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        if (ent_q.key > ram_rd.key) begin
          ram_we  = 1'b1;
          ram_wd  = ram_rd;
          hole_d  = IDX_W'((hole_q - 1'b1) >> 1);
          mv_d    = 1'b1;
          state_d = S_PU_RD;
        end else if (sd_q && !mv_q) begin
          state_d = S_SD_L;
        end else begin
          state_d = S_WR_FIN;
        end
      end
      S_SR_RD: begin
        ram_ra  = scan_q[IDX_W-1:0];
        state_d = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (ram_rd.tag == tag_q) begin
          hole_d  = scan_q[IDX_W-1:0];
          oe_d    = ram_rd;
          state_d = S_LS_RD;
        end else if (scan_q + 1'b1 == cnt_q) begin
          st_d    = ST_NOTFOUND;
          state_d = S_TOP_RD;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_SR_RD;
        end
      end
      S_TK_RD: begin
        state_d = S_TK_GOT;
      end
      S_TK_GOT: begin
        oe_d    = ram_rd;
        state_d = S_LS_RD;
      end
      S_LS_RD: begin
        ram_ra  = cnt_dec[IDX_W-1:0];
        state_d = S_LS_GOT;
      end
      S_LS_GOT: begin
        ent_d = ram_rd;
        cnt_d = cnt_dec;
        ov_d  = 1'b1;
        // Refill the hole with the last entry unless the hole was the last
        if (CNT_W'(hole_q) < cnt_dec) begin
          sd_d    = 1'b1;
          state_d = S_PU_RD;
        end else begin
          state_d = S_TOP_RD;
        end
      end
      S_SD_L: begin
        chi_d = lchild;
        if (lchild >= CHD_W'(cnt_q)) begin
          state_d = S_WR_FIN;
        end else begin
          ram_ra  = lchild[IDX_W-1:0];
          state_d = S_SD_R;
        end
      end
      S_SD_R: begin
        best_d  = ram_rd;
        ram_ra  = rchild[IDX_W-1:0];
        state_d = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (cand.key > ent_q.key) begin
          ram_we  = 1'b1;
          ram_wd  = cand;
          hole_d  = cand_i[IDX_W-1:0];
          state_d = S_SD_L;
        end else begin
          state_d = S_WR_FIN;
        end
      end
      S_WR_FIN: begin
        ram_we  = 1'b1;
        state_d = S_TOP_RD;
      end
      S_TOP_RD: begin
        ram_ra  = '0;
        state_d = S_TOP_GT;
      end
      S_TOP_GT: begin
        top_d   = (cnt_q == '0) ? '0 : ram_rd;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    scan_q <= scan_d;
    ent_q  <= ent_d;
    best_q <= best_d;
    chi_q  <= chi_d;
    sd_q   <= sd_d;
    mv_q   <= mv_d;
    tag_q  <= tag_d;
    st_q   <= st_d;
    ov_q   <= ov_d;
    oe_q   <= oe_d;
    top_q  <= top_d;
  end

  // Hold the input side while a request is in flight
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    out_data_o.status      = st_q;
    out_data_o.out_valid   = ov_q;
    out_data_o.out_key     = oe_q.key;
    out_data_o.out_tag     = oe_q.tag;
    out_data_o.top_valid   = (cnt_q != '0);
    out_data_o.top_key     = top_q.key;
    out_data_o.top_tag     = top_q.tag;
    out_data_o.entry_count = cnt_q;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY)) else $error("count past capacity");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result pending");

  a_ov_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_valid) |-> (out_data_o.status == ST_OK))
    else $error("entry returned with error status");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_valid_i) |=> $stable(cnt_q))
    else $error("count changed while idle");
endmodule
`default_nettype wire

[tb/tb_priority_queue_heap.sv]
`timescale 1ns / 1ps

module tb_priority_queue_heap;
  import pqh_pkg::*;

  // Scoreboard: a plain multiset of held entries stands in for the heap.
  // Among equal keys the service order is free, and among duplicate tags
  // the remove may take any holder. The result beat names which entry went,
  // and the mirror drops exactly that one.
  class heap_scoreboard;
    req_t   pending_reqs[$];
    entry_t held[$];
    int     errors;
    int     checked;
    int     full_hits;
    int     empty_hits;
    int     miss_hits;

    function void note_request(req_t r);
      pending_reqs.push_back(r);
    endfunction

    function int pending();
      return pending_reqs.size();
    endfunction

    function logic [KEY_BITS-1:0] max_key();
      logic [KEY_BITS-1:0] m;
      m = '0;
      foreach (held[i]) if (held[i].key > m) m = held[i].key;
      return m;
    endfunction

    function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    // Check one result beat against the oldest request and advance the mirror.
    function void check_result(rsp_t rsp);
      req_t                r;
      status_e             exp_st;
      logic                exp_ov;
      logic [KEY_BITS-1:0] exp_ok;
      logic [TAG_BITS-1:0] exp_ot;
      logic [KEY_BITS-1:0] m;
      int                  pick;
      int                  first;
      entry_t              e;
      if (pending_reqs.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      r      = pending_reqs.pop_front();
      exp_st = ST_OK;
      exp_ov = 1'b0;
      exp_ok = '0;
      exp_ot = '0;
      checked++;
      case (req_type_e'(r.req_type))
        REQ_PUSH: begin
          if (held.size() >= CAPACITY) begin
            exp_st = ST_FULL;
            full_hits++;
          end else begin
            e.key = r.entry_key;
            e.tag = r.entry_tag;
            held.push_back(e);
          end
        end
        REQ_POP: begin
          if (held.size() == 0) begin
            exp_st = ST_EMPTY;
            empty_hits++;
          end else begin
            m = max_key();
            exp_ov = 1'b1;
            exp_ok = m;
            pick = -1;
            first = -1;
            foreach (held[i]) if (held[i].key == m) begin
              if (first < 0) first = i;
              if (pick < 0 && held[i].tag == rsp.out_tag) pick = i;
            end
            // Any tag of a top-key entry is fine; fall back to the first one.
            exp_ot = (pick >= 0) ? rsp.out_tag : held[first].tag;
            held.delete((pick >= 0) ? pick : first);
          end
        end
        REQ_REMOVE: begin
          pick = -1;
          first = -1;
          foreach (held[i]) if (held[i].tag == r.entry_tag) begin
            if (first < 0) first = i;
            if (pick < 0 && held[i].key == rsp.out_key) pick = i;
          end
          if (first < 0) begin
            exp_st = ST_NOTFOUND;
            miss_hits++;
          end else begin
            exp_ov = 1'b1;
            exp_ot = r.entry_tag;
            exp_ok = (pick >= 0) ? rsp.out_key : held[first].key;
            held.delete((pick >= 0) ? pick : first);
          end
        end
        default: ;
      endcase
      compare("status", 64'(exp_st), 64'(rsp.status));
      compare("out_valid", 64'(exp_ov), 64'(rsp.out_valid));
      compare("out_key", 64'(exp_ok), 64'(rsp.out_key));
      compare("out_tag", 64'(exp_ot), 64'(rsp.out_tag));
      compare("top_valid", 64'(held.size() != 0), 64'(rsp.top_valid));
      if (held.size() == 0) begin
        compare("top_key", 64'(0), 64'(rsp.top_key));
        compare("top_tag", 64'(0), 64'(rsp.top_tag));
      end else begin
        m = max_key();
        compare("top_key", 64'(m), 64'(rsp.top_key));
        first = -1;
        pick = -1;
        foreach (held[i]) if (held[i].key == m) begin
          if (first < 0) first = i;
          if (held[i].tag == rsp.top_tag) pick = i;
        end
        compare("top_tag", 64'((pick >= 0) ? rsp.top_tag : held[first].tag),
                64'(rsp.top_tag));
      end
      compare("entry_count", 64'(held.size()), 64'(rsp.entry_count));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  heap_scoreboard sb;
  int             push_bias;

  priority_queue_heap i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  // Offer one request beat; hold it until taken. Keep valid high across
  // back-to-back beats rather than dropping and raising it in one step.
  task automatic send_request(input req_type_e kind, input logic [KEY_BITS-1:0] key,
                              input logic [TAG_BITS-1:0] tag, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.req_type  <= kind;
    in_data.entry_key <= key;
    in_data.entry_tag <= tag;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_request(in_data);
  endtask

  // Tag of some held entry, or a random one when nothing is held.
  function logic [TAG_BITS-1:0] held_tag();
    if (sb.held.size() == 0) return TAG_BITS'($urandom_range(0, 65535));
    return sb.held[$urandom_range(0, sb.held.size() - 1)].tag;
  endfunction

  task automatic send_random();
    int                  roll;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    req_type_e           kind;
    roll = $urandom_range(0, 99);
    // Narrow keys now and then, so ties turn up.
    key = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom();
    tag = ($urandom_range(0, 9) == 0) ? held_tag() : TAG_BITS'($urandom_range(0, 65535));
    if (roll < push_bias) kind = REQ_PUSH;
    else if (roll < push_bias + (96 - push_bias) / 2) kind = REQ_POP;
    else if (roll < 96) begin
      kind = REQ_REMOVE;
      tag = ($urandom_range(0, 4) != 0) ? held_tag() : TAG_BITS'($urandom_range(0, 65535));
    end else kind = REQ_NONE;
    send_request(kind, key, tag, pick_gap());
  endtask

  // Result side: take beats on handshake, stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if ($urandom_range(0, 9) < 6) out_stall <= 1'b0;
    else if ($urandom_range(0, 9) < 8) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 1) == 1);
  end

  initial begin
    int n;
    sb        = new();
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    push_bias = 50;
    rst_n     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, unused kind, field extremes, ties, duplicates.
    send_request(REQ_POP, '0, '0, 0);
    send_request(REQ_REMOVE, '0, 16'h1234, 0);
    send_request(REQ_NONE, '1, '1, 1);
    send_request(REQ_PUSH, '0, '0, 0);
    send_request(REQ_PUSH, '1, '1, 0);
    send_request(REQ_PUSH, 32'h8000_0000, 16'h8000, 2);
    send_request(REQ_PUSH, 32'h8000_0000, 16'h0001, 0);
    send_request(REQ_PUSH, 32'h0000_0001, 16'h0001, 0);
    send_request(REQ_NONE, '0, '0, 0);
    send_request(REQ_POP, '0, '0, 0);
    send_request(REQ_REMOVE, '0, 16'h0001, 0);
    send_request(REQ_REMOVE, '0, 16'hbeef, 3);
    send_request(REQ_REMOVE, '0, 16'h0000, 0);
    send_request(REQ_POP, '1, '1, 0);
    send_request(REQ_POP, '0, '0, 0);
    send_request(REQ_POP, '0, '0, 0);
    send_request(REQ_POP, '0, '0, 0);
    send_request(REQ_REMOVE, '0, '1, 0);

    // Random: phases lean to filling up to full, or to draining empty.
    n = 0;
    while (n < 550) begin
      case ($urandom_range(0, 2))
        0: push_bias = 85;
        1: push_bias = 10;
        default: push_bias = 45;
      endcase
      repeat ($urandom_range(40, 150)) begin
        if (n < 550) begin
          send_random();
          n++;
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d requests: %0d pushes on full, %0d pops on empty, %0d unknown tags",
             sb.checked, sb.full_hits, sb.empty_hits, sb.miss_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
